// ----- rtl/cwfw_pkg.sv -----
// ----------------------------------------------------------------------------
// cwfw_pkg
// Types and codes shared by the clipped-window frame-buffer writer.
// ----------------------------------------------------------------------------
`default_nettype none

package cwfw_pkg;

	// item kinds
	localparam logic [1:0] KIND_SET_WIN = 2'd0;
	localparam logic [1:0] KIND_WRITE   = 2'd1;
	localparam logic [1:0] KIND_READ    = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] x_start;
		logic signed [15:0] y_start;
		logic signed [15:0] x_end;
		logic signed [15:0] y_end;
		logic [15:0]        pixel;
	} cwfw_in_t;

	typedef struct packed {
		logic [15:0] read_pixel;
		logic        written;
		logic        window_active;
	} cwfw_out_t;

	// memory access strobes from the control stage
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} cwfw_mem_ctl_t;

	// result flags held in the result register
	typedef struct packed {
		logic valid;
		logic is_read;
		logic written;
		logic active;
	} cwfw_flags_t;

endpackage

`default_nettype wire

// ----- rtl/clipped_window_framebuffer_writer.sv -----
// ----------------------------------------------------------------------------
// clipped_window_framebuffer_writer
// Frame-buffer store written through a clipped display address window.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken on a rising edge with start high and busy low. Kinds are
//   set window (clips corners, parks the cursor at the top-left), write pixel
//   (stores at the cursor and steps it in raster order) and read pixel.
//   Every item gives one result on result, marked by done for one cycle.
//   Each result passes the input register and then the result register
//   around the control logic.
//   Throughput: one item per clock while busy is low; the memory has one write
//   and one read port, and a read sees every earlier write.
//   Reset: the cursor, window and active flag clear at once; then the store
//   is swept to zero one entry per cycle over all SCREEN_WIDTH * SCREEN_HEIGHT
//   entries (76800 at the defaults), with busy high and no item taken.
//   The receiver cannot stall: a result is on the ports for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_window_framebuffer_writer import cwfw_pkg::*; #(
	parameter int SCREEN_WIDTH  = 240,
	parameter int SCREEN_HEIGHT = 320
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire cwfw_in_t  item,
	output logic           done,
	output cwfw_out_t      result
);

	localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cwfw_mem_ctl_t     mem_ctl;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [15:0]       wdata, rdata;
	logic              clearing;
	cwfw_flags_t       flags;

	cwfw_ctrl #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.ADDR_W       (ADDR_W)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (start && !clearing),
		.item   (item),
		.mem_ctl(mem_ctl),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr  (raddr),
		.flags  (flags)
	);

	cwfw_store #(
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_ctl (mem_ctl),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr   (raddr),
		.rdata   (rdata),
		.clearing(clearing)
	);

	always_comb begin
		busy                 = clearing;
		done                 = flags.valid;
		result.read_pixel    = flags.is_read ? rdata : 16'h0000;
		result.written       = flags.written;
		result.window_active = flags.active;
	end

endmodule

`default_nettype wire

// ----- rtl/cwfw_store.sv -----
// ----------------------------------------------------------------------------
// cwfw_store
// Pixel memory with one write and one registered read port. After reset it
// sweeps every entry to zero, one per cycle, and reports clearing meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module cwfw_store import cwfw_pkg::*; #(
	parameter int DEPTH  = 76800,
	parameter int ADDR_W = 17
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cwfw_mem_ctl_t       mem_ctl,
	input  wire logic [ADDR_W-1:0]   waddr,
	input  wire logic [15:0]         wdata,
	input  wire logic [ADDR_W-1:0]   raddr,
	output logic [15:0]              rdata,
	output logic                     clearing
);

	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

	logic [15:0]       mem [DEPTH];
	logic [ADDR_W-1:0] clr_q;
	logic              clearing_q;
	logic              we;
	logic [ADDR_W-1:0] wa;
	logic [15:0]       wd;
	logic [15:0]       rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_q == LAST) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		we = clearing_q | mem_ctl.wr_en;
		wa = clearing_q ? clr_q : waddr;
		wd = clearing_q ? 16'h0000 : wdata;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_ctl.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata    = rdata_q;
	assign clearing = clearing_q;

endmodule

`default_nettype wire

// ----- rtl/cwfw_ctrl.sv -----
// ----------------------------------------------------------------------------
// cwfw_ctrl
// Input register, window clipping, cursor and address logic, and the result
// flags register.
// ----------------------------------------------------------------------------
`default_nettype none

module cwfw_ctrl import cwfw_pkg::*; #(
	parameter int SCREEN_WIDTH  = 240,
	parameter int SCREEN_HEIGHT = 320,
	parameter int ADDR_W        = 17
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire cwfw_in_t          item,
	output cwfw_mem_ctl_t          mem_ctl,
	output logic [ADDR_W-1:0]      waddr,
	output logic [15:0]            wdata,
	output logic [ADDR_W-1:0]      raddr,
	output cwfw_flags_t            flags
);

	localparam int COL_W = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
	localparam int ROW_W = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
	localparam logic signed [15:0] XMAX = 16'(SCREEN_WIDTH - 1);
	localparam logic signed [15:0] YMAX = 16'(SCREEN_HEIGHT - 1);
	localparam logic [ADDR_W-1:0]  W_A  = ADDR_W'(SCREEN_WIDTH);

	logic              valid_s1;
	cwfw_in_t          item_s1;
	cwfw_flags_t       flags_s2;

	logic [COL_W-1:0]  cur_col_q, win_left_q, win_right_q;
	logic [ROW_W-1:0]  cur_row_q, win_bottom_q;
	logic              active_q;

	logic signed [15:0] x1, y1, x2, y2;
	logic              empty, is_set, is_wr, is_rd, do_wr, in_range, wrap, done_win;
	logic              active_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		is_set = valid_s1 && (item_s1.kind == KIND_SET_WIN);
		is_wr  = valid_s1 && (item_s1.kind == KIND_WRITE);
		is_rd  = valid_s1 && (item_s1.kind == KIND_READ);

		// clip corners to the screen
		x1 = item_s1.x_start[15] ? 16'sd0 : item_s1.x_start;
		y1 = item_s1.y_start[15] ? 16'sd0 : item_s1.y_start;
		x2 = (item_s1.x_end > XMAX) ? XMAX : item_s1.x_end;
		y2 = (item_s1.y_end > YMAX) ? YMAX : item_s1.y_end;
		empty = (x1 > x2) || (y1 > y2);

		do_wr    = is_wr && active_q;
		wrap     = cur_col_q >= win_right_q;
		done_win = wrap && (cur_row_q >= win_bottom_q);

		in_range = !item_s1.x_start[15] && !item_s1.y_start[15]
			&& (item_s1.x_start <= XMAX) && (item_s1.y_start <= YMAX);

		active_nx = active_q;
		if (is_set) begin
			active_nx = !empty;
		end else if (do_wr && done_win) begin
			active_nx = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			win_left_q   <= '0;
			win_right_q  <= '0;
			win_bottom_q <= '0;
			active_q     <= 1'b0;
			flags_s2     <= '0;
		end else begin
			active_q <= active_nx;
			if (is_set && !empty) begin
				win_left_q   <= x1[COL_W-1:0];
				win_right_q  <= x2[COL_W-1:0];
				win_bottom_q <= y2[ROW_W-1:0];
				cur_col_q    <= x1[COL_W-1:0];
				cur_row_q    <= y1[ROW_W-1:0];
			end else if (do_wr) begin
				if (wrap) begin
					cur_col_q <= win_left_q;
					if (!done_win) begin
						cur_row_q <= cur_row_q + 1'b1;
					end
				end else begin
					cur_col_q <= cur_col_q + 1'b1;
				end
			end
			flags_s2.valid   <= valid_s1;
			flags_s2.is_read <= is_rd && in_range;
			flags_s2.written <= do_wr;
			flags_s2.active  <= active_nx;
		end
	end

	always_comb begin
		mem_ctl.wr_en = do_wr;
		mem_ctl.rd_en = is_rd && in_range;
		waddr = ADDR_W'(cur_row_q) * W_A + ADDR_W'(cur_col_q);
		wdata = item_s1.pixel;
		raddr = ADDR_W'(item_s1.y_start[ROW_W-1:0]) * W_A
			+ ADDR_W'(item_s1.x_start[COL_W-1:0]);
	end

	assign flags = flags_s2;

endmodule

`default_nettype wire

// ----- rtl/cwfw_chk.sv -----
// ----------------------------------------------------------------------------
// cwfw_chk
// Port-level checks of the frame-buffer writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cwfw_chk import cwfw_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      start,
	input wire logic      busy,
	input wire logic      done,
	input wire cwfw_out_t result
);

	// every accepted item gives its result after the input and result registers
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("item accepted without a result two cycles later");

	// no result without an earlier accepted item
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without an accepted item");

	// a stored pixel never returns read data
	a_write_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.written |-> result.read_pixel == 16'h0000)
		else $error("written item carries read data");

	// nothing comes out while the store is being cleared
	a_busy_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result during clearing sweep");

endmodule

bind clipped_window_framebuffer_writer cwfw_chk u_chk (.*);

`default_nettype wire

// ----- sim/clipped_window_framebuffer_writer_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clipped_window_framebuffer_writer_test
// Self-checking bench for the clipped-window frame-buffer writer. A directed
// table covers reset contents, clipping, empty windows, window overrun and
// out-of-range reads; random window bursts with readback and random noise
// items follow. A shadow frame store and cursor predict each result that the table does not give.
// ----------------------------------------------------------------------------

module clipped_window_framebuffer_writer_test;
	import cwfw_pkg::*;

	localparam int SCREEN_W    = 240;
	localparam int SCREEN_H    = 320;
	localparam int ITEM_COUNT  = 1000;
	localparam int STALL_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 8;

	// kind with no meaning, ignored by the block
	localparam logic [1:0] KIND_NONE = 2'd3;

	typedef struct {
		cwfw_in_t  stim;
		bit        typed;
		cwfw_out_t want;
	} plan_row_t;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	cwfw_in_t  item   = '0;
	logic      busy;
	logic      done;
	cwfw_out_t result;

	// shadow of the block state
	logic [15:0] fb_shadow [SCREEN_W * SCREEN_H];
	logic [7:0]  cur_col;
	logic [8:0]  cur_row;
	logic [7:0]  win_left;
	logic [7:0]  win_right;
	logic [8:0]  win_bottom;
	bit          win_on;

	cwfw_out_t pending_results[$];
	int        errors;
	int        stall_cycles;
	int        sent;
	bit        no_idle;

	clipped_window_framebuffer_writer #(
		.SCREEN_WIDTH(SCREEN_W),
		.SCREEN_HEIGHT(SCREEN_H)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	always #4 clk = ~clk;

	function automatic cwfw_in_t mk_item(logic [1:0] kind, int xs, int ys, int xe, int ye,
			int px);
		cwfw_in_t it;
		it.kind    = kind;
		it.x_start = xs[15:0];
		it.y_start = ys[15:0];
		it.x_end   = xe[15:0];
		it.y_end   = ye[15:0];
		it.pixel   = px[15:0];
		return it;
	endfunction

	function automatic cwfw_out_t mk_res(int rd, bit wr, bit act);
		cwfw_out_t r;
		r.read_pixel    = rd[15:0];
		r.written       = wr;
		r.window_active = act;
		return r;
	endfunction

	function automatic plan_row_t plan_entry(cwfw_in_t s, bit typed, cwfw_out_t want);
		plan_row_t p;
		p.stim  = s;
		p.typed = typed;
		p.want  = want;
		return p;
	endfunction

	// apply one item to the shadow state and return its result
	function automatic cwfw_out_t step_shadow(cwfw_in_t it);
		cwfw_out_t r;
		int x1, y1, x2, y2;
		r  = '0;
		x1 = $signed(it.x_start);
		y1 = $signed(it.y_start);
		x2 = $signed(it.x_end);
		y2 = $signed(it.y_end);
		case (it.kind)
			KIND_SET_WIN: begin
				if (x1 < 0) x1 = 0;
				if (y1 < 0) y1 = 0;
				if (x2 >= SCREEN_W) x2 = SCREEN_W - 1;
				if (y2 >= SCREEN_H) y2 = SCREEN_H - 1;
				if (x1 > x2 || y1 > y2) begin
					win_on = 1'b0;
				end else begin
					win_left   = x1[7:0];
					win_right  = x2[7:0];
					win_bottom = y2[8:0];
					cur_col    = x1[7:0];
					cur_row    = y1[8:0];
					win_on     = 1'b1;
				end
			end
			KIND_WRITE: begin
				if (win_on && cur_col < SCREEN_W && cur_row < SCREEN_H) begin
					fb_shadow[cur_row * SCREEN_W + cur_col] = it.pixel;
					r.written = 1'b1;
					if (cur_col >= win_right) begin
						cur_col = win_left;
						if (cur_row >= win_bottom)
							win_on = 1'b0;
						else
							cur_row++;
					end else begin
						cur_col++;
					end
				end
			end
			KIND_READ: begin
				if (x1 >= 0 && y1 >= 0 && x1 < SCREEN_W && y1 < SCREEN_H)
					r.read_pixel = fb_shadow[y1 * SCREEN_W + x1];
			end
			default: ;
		endcase
		r.window_active = win_on;
		return r;
	endfunction

	task automatic send_item(input cwfw_in_t it, input bit typed, input cwfw_out_t want);
		int unsigned gap;
		cwfw_out_t predicted;
		if ($urandom_range(0, 39) == 0)
			no_idle = !no_idle;
		gap = no_idle ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		predicted = step_shadow(it);
		pending_results.push_back(typed ? want : predicted);
		if (it.kind != KIND_NONE)
			sent++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// set a window, stream pixels into it, maybe read the area back
	task automatic run_window_burst();
		int xl, yt, xr, yb, w, h, n;
		cwfw_in_t it;
		w  = $urandom_range(1, 8);
		h  = $urandom_range(1, 6);
		xl = $urandom_range(0, SCREEN_W - 1);
		yt = $urandom_range(0, SCREEN_H - 1);
		xr = xl + w - 1;
		yb = yt + h - 1;
		case ($urandom_range(0, 9))
			0: xl = -int'($urandom_range(1, 32768));
			1: yt = -int'($urandom_range(1, 32768));
			2: xr = $urandom_range(SCREEN_W, 32767);
			3: yb = $urandom_range(SCREEN_H, 32767);
			4: xr = xl - 1;
			5: yb = yt - 1;
			default: ;
		endcase
		send_item(mk_item(KIND_SET_WIN, xl, yt, xr, yb, $urandom), 1'b0, '0);
		n = $urandom_range(1, w * h + 3);
		repeat (n) begin
			if ($urandom_range(0, 5) == 0)
				it = mk_item(KIND_READ, xl + $urandom_range(0, w + 1) - 1,
					yt + $urandom_range(0, h + 1) - 1, $urandom, $urandom, $urandom);
			else
				it = mk_item(KIND_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom);
			send_item(it, 1'b0, '0);
		end
		if ($urandom_range(0, 1) == 0) begin
			for (int r = 0; r < h; r++)
				for (int c = 0; c < w; c++)
					send_item(mk_item(KIND_READ, xl + c, yt + r, $urandom, $urandom, $urandom),
						1'b0, '0);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		cwfw_out_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no item pending: %p", result);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (result.read_pixel !== want.read_pixel) begin
					$error("read_pixel: expected %h, got %h", want.read_pixel, result.read_pixel);
					errors++;
				end
				if (result.written !== want.written) begin
					$error("written: expected %b, got %b", want.written, result.written);
					errors++;
				end
				if (result.window_active !== want.window_active) begin
					$error("window_active: expected %b, got %b", want.window_active,
						result.window_active);
					errors++;
				end
			end
		end
	end

	// watchdog, long enough for the store sweep after reset
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		plan_row_t plan[$];
		bit paused;
		foreach (fb_shadow[i])
			fb_shadow[i] = '0;
		cur_col      = '0;
		cur_row      = '0;
		win_left     = '0;
		win_right    = '0;
		win_bottom   = '0;
		win_on       = 1'b0;
		errors       = 0;
		stall_cycles = 0;
		sent         = 0;
		no_idle      = 1'b0;
		paused       = 1'b0;

		// store clear after reset, reads at the screen corners and outside it, a write with no window and an ignored kind
		plan.push_back(plan_entry(mk_item(KIND_READ, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 0)));
		plan.push_back(plan_entry(mk_item(KIND_READ, 239, 319, 0, 0, 0), 1, mk_res(0, 0, 0)));
		plan.push_back(plan_entry(mk_item(KIND_WRITE, 0, 0, 0, 0, 'hFFFF), 1, mk_res(0, 0, 0)));
		plan.push_back(plan_entry(mk_item(KIND_READ, -1, 0, 0, 0, 0), 1, mk_res(0, 0, 0)));
		plan.push_back(plan_entry(mk_item(KIND_READ, 240, 0, 0, 0, 0), 1, mk_res(0, 0, 0)));
		plan.push_back(plan_entry(mk_item(KIND_READ, 0, 320, 0, 0, 0), 1, mk_res(0, 0, 0)));
		plan.push_back(plan_entry(mk_item(KIND_READ, -32768, 32767, 0, 0, 0), 1,
			mk_res(0, 0, 0)));
		plan.push_back(plan_entry(mk_item(KIND_NONE, -1, -1, -1, -1, 'hFFFF), 1,
			mk_res(0, 0, 0)));
		// full clip to the whole screen
		plan.push_back(plan_entry(mk_item(KIND_SET_WIN, -32768, -32768, 32767, 32767, 0), 1,
			mk_res(0, 0, 1)));
		plan.push_back(plan_entry(mk_item(KIND_WRITE, 0, 0, 0, 0, 'hFFFF), 1, mk_res(0, 1, 1)));
		plan.push_back(plan_entry(mk_item(KIND_READ, 0, 0, 0, 0, 0), 1, mk_res('hFFFF, 0, 1)));
		// empty window drops pixels
		plan.push_back(plan_entry(mk_item(KIND_SET_WIN, 10, 0, 9, 5, 0), 1, mk_res(0, 0, 0)));
		plan.push_back(plan_entry(mk_item(KIND_WRITE, 0, 0, 0, 0, 'h1234), 1, mk_res(0, 0, 0)));
		// single pixel at the far corner, then overrun
		plan.push_back(plan_entry(mk_item(KIND_SET_WIN, 239, 319, 239, 319, 0), 1,
			mk_res(0, 0, 1)));
		plan.push_back(plan_entry(mk_item(KIND_WRITE, 0, 0, 0, 0, 'h8001), 1, mk_res(0, 1, 0)));
		plan.push_back(plan_entry(mk_item(KIND_WRITE, 0, 0, 0, 0, 'h5555), 1, mk_res(0, 0, 0)));
		plan.push_back(plan_entry(mk_item(KIND_READ, 239, 319, 0, 0, 0), 1,
			mk_res('h8001, 0, 0)));
		// 2x2 after clipping negative starts
		plan.push_back(plan_entry(mk_item(KIND_SET_WIN, -5, -5, 1, 1, 0), 1, mk_res(0, 0, 1)));
		plan.push_back(plan_entry(mk_item(KIND_WRITE, 0, 0, 0, 0, 'h0001), 0, '0));
		plan.push_back(plan_entry(mk_item(KIND_WRITE, 0, 0, 0, 0, 'h0002), 0, '0));
		plan.push_back(plan_entry(mk_item(KIND_WRITE, 0, 0, 0, 0, 'h0004), 0, '0));
		plan.push_back(plan_entry(mk_item(KIND_WRITE, 0, 0, 0, 0, 'hF800), 0, '0));
		plan.push_back(plan_entry(mk_item(KIND_READ, 1, 1, 0, 0, 0), 0, '0));
		// starts past the screen leave nothing
		plan.push_back(plan_entry(mk_item(KIND_SET_WIN, 240, 0, 300, 10, 0), 1,
			mk_res(0, 0, 0)));
		plan.push_back(plan_entry(mk_item(KIND_SET_WIN, 0, 320, 5, 400, 0), 1,
			mk_res(0, 0, 0)));
		// ignored kind keeps an open window open
		plan.push_back(plan_entry(mk_item(KIND_SET_WIN, 100, 100, 102, 100, 0), 1,
			mk_res(0, 0, 1)));
		plan.push_back(plan_entry(mk_item(KIND_NONE, -1, -1, -1, -1, 'hFFFF), 1,
			mk_res(0, 0, 1)));
		plan.push_back(plan_entry(mk_item(KIND_WRITE, 0, 0, 0, 0, 'h07E0), 0, '0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_item(plan[i].stim, plan[i].typed, plan[i].want);

		while (sent < ITEM_COUNT) begin
			if (!paused && sent >= ITEM_COUNT / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			if ($urandom_range(0, 3) == 0)
				send_item(mk_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
					$urandom, $urandom), 1'b0, '0);
			else
				run_window_burst();
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
